### src/barrier_sync_table_assert.svh
// Assertion macros for the barrier table checker.
// Expect clk and rst_n in the scope of each use.
`ifndef BARRIER_SYNC_TABLE_ASSERT_SVH
`define BARRIER_SYNC_TABLE_ASSERT_SVH

// Same-cycle implication.
`define BST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bst_pkg.sv
// Shared constants and types of the barrier table.
// No dependencies.
package bst_pkg;

  localparam int BARRIER_COUNT = 8;
  localparam int PROCESS_COUNT = 16;
  localparam int MASK_W        = 16;
  localparam int ADDR_W        = (BARRIER_COUNT > 1) ? $clog2(BARRIER_COUNT) : 1;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_WAIT    = 2'd1;
  localparam logic [1:0] MODE_DESTROY = 2'd2;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_REFUSED = 2'd2;
  localparam logic [1:0] STAT_BLOCKED = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [7:0]        goal;
    logic [7:0]        count;
    logic [MASK_W-1:0] mask;
  } entry_t;

endpackage

### src/bst_if.sv
// Request and result channel interfaces of the barrier table.
// Depends on nothing but the field widths of the block.
interface bst_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [2:0] barrier_index;
  logic [7:0] goal;
  logic [3:0] process_id;

  modport source (output valid, mode, barrier_index, goal, process_id, input ready);
  modport sink   (input valid, mode, barrier_index, goal, process_id, output ready);
endinterface

interface bst_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  result_index;
  logic [15:0] release_mask;

  modport source (output valid, status, result_index, release_mask, input ready);
  modport sink   (input valid, status, result_index, release_mask, output ready);
endinterface

### src/barrier_sync_table.sv
// Top level of the counting barrier table: entry memory and request sequencer.
// Depends on bst_pkg and the channel interfaces in bst_if.sv.
//
//   channel  dir  payload                                  transfer when
//   in_ch    in   mode, barrier_index, goal, process_id    valid && ready
//   out_ch   out  status, result_index, release_mask       valid && ready
//
// Each request is read, then modified: the entry is read from the registered
// memory at the transfer edge, then the modify and write-back step loads the
// result register. A new request is taken while a result waits in out_ch.
// Reset clears the per-entry valid flags and sets the free flags at once; no clearing pass.
// A held result stalls the write-back cycle until out_ch.ready.
module barrier_sync_table
  import bst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bst_in_if.sink      in_ch,
  bst_out_if.source   out_ch
);

  entry_t mem [BARRIER_COUNT];

  state_t state_r, state_nxt;

  logic [1:0]        req_mode_r;
  logic [2:0]        req_index_r;
  logic [7:0]        req_goal_r;
  logic [3:0]        req_pid_r;

  entry_t            rd_data_r;
  logic              rd_valid_r;
  logic [BARRIER_COUNT-1:0] valid_r;
  logic [BARRIER_COUNT-1:0] free_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [2:0]        out_index_r;
  logic [MASK_W-1:0] out_mask_r;

  logic              accept;
  logic              exec_done;
  logic [ADDR_W+2:0] in_idx_ext;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W+2:0] req_idx_ext;
  logic [ADDR_W-1:0] req_addr;
  logic              req_in_range;

  entry_t            cur;
  logic              alloc_hit;
  logic [ADDR_W-1:0] alloc_addr;
  logic [ADDR_W+2:0] alloc_idx_ext;
  logic [7:0]        cnt_inc;
  logic [MASK_W-1:0] pid_bit;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  logic [1:0]        res_status;
  logic [2:0]        res_index;
  logic [MASK_W-1:0] res_mask;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_idx_ext  = {{ADDR_W{1'b0}}, in_ch.barrier_index};
  assign rd_addr     = in_idx_ext[ADDR_W-1:0];
  assign req_idx_ext = {{ADDR_W{1'b0}}, req_index_r};
  assign req_addr    = req_idx_ext[ADDR_W-1:0];
  assign req_in_range = 32'(req_index_r) < BARRIER_COUNT;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    exec_done   = 1'b0;
    case (state_r)
      S_IDLE:  in_ch.ready = 1'b1;
      S_EXEC:  exec_done   = !out_valid_r || out_ch.ready;
      default: begin
        in_ch.ready = 1'b0;
        exec_done   = 1'b0;
      end
    endcase
  end

  always_comb begin
    alloc_addr = '0;
    for (int i = BARRIER_COUNT - 1; i >= 0; i--) begin
      if (free_r[i]) alloc_addr = ADDR_W'(i);
    end
  end

  assign alloc_hit     = |free_r;
  assign alloc_idx_ext = {3'b000, alloc_addr};
  assign cur           = rd_valid_r ? rd_data_r : '0;
  assign cnt_inc       = (cur.count == 8'hFF) ? 8'hFF : 8'(cur.count + 8'd1);
  assign pid_bit       = ((32'(req_pid_r) < PROCESS_COUNT) && (32'(req_pid_r) < MASK_W))
                         ? (MASK_W'(1) << req_pid_r) : '0;

  // Modify the entry and form the result.
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = req_addr;
    wr_data    = cur;
    res_status = STAT_DONE;
    res_index  = '0;
    res_mask   = '0;
    case (req_mode_r)
      MODE_ALLOC: begin
        if (alloc_hit) begin
          wr_en     = 1'b1;
          wr_addr   = alloc_addr;
          wr_data   = '{goal: req_goal_r, count: 8'd0, mask: '0};
          res_index = alloc_idx_ext[2:0];
        end else begin
          res_status = STAT_FULL;
        end
      end
      MODE_WAIT: begin
        if (req_in_range) begin
          wr_en = 1'b1;
          if (cnt_inc < cur.goal) begin
            wr_data    = '{goal: cur.goal, count: cnt_inc, mask: cur.mask | pid_bit};
            res_status = STAT_BLOCKED;
          end else begin
            wr_data  = '{goal: cur.goal, count: 8'd0, mask: '0};
            res_mask = cur.mask;
          end
        end
      end
      MODE_DESTROY: begin
        if (req_in_range) begin
          if (cur.mask == '0) begin
            wr_en   = 1'b1;
            wr_data = '{goal: 8'd0, count: 8'd0, mask: '0};
          end else begin
            res_status = STAT_REFUSED;
          end
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (exec_done && wr_en) mem[wr_addr] <= wr_data;
    if (accept) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode_r  <= in_ch.mode;
      req_index_r <= in_ch.barrier_index;
      req_goal_r  <= in_ch.goal;
      req_pid_r   <= in_ch.process_id;
    end
    if (exec_done) begin
      out_status_r <= res_status;
      out_index_r  <= res_index;
      out_mask_r   <= res_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      free_r      <= '1;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) rd_valid_r <= valid_r[rd_addr];
      if (exec_done && wr_en) begin
        valid_r[wr_addr] <= 1'b1;
        free_r[wr_addr]  <= (wr_data.goal == 8'd0);
      end
      if (exec_done)          out_valid_r <= 1'b1;
      else if (out_ch.ready)  out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.result_index = out_index_r;
  assign out_ch.release_mask = out_mask_r;

endmodule

### src/bst_checker.sv
// Port-level checks of the barrier table, bound to its top level.
// Depends on bst_pkg, bst_if.sv and barrier_sync_table_assert.svh.
`include "barrier_sync_table_assert.svh"

module bst_checker
  import bst_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [2:0]  out_result_index,
  input logic [15:0] out_release_mask
);

  `BST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_result_index) && $stable(out_release_mask), "result changed while stalled")
  `BST_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request taken during execution")
  `BST_ASSERT_NOW(a_full_clean, out_valid && out_status == STAT_FULL, out_result_index == 3'd0 && out_release_mask == 16'd0, "full result carries data")
  `BST_ASSERT_NOW(a_blocked_clean, out_valid && (out_status == STAT_BLOCKED || out_status == STAT_REFUSED), out_result_index == 3'd0 && out_release_mask == 16'd0, "blocked or refused result carries data")

endmodule

bind barrier_sync_table bst_checker u_bst_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_result_index (out_ch.result_index),
  .out_release_mask (out_ch.release_mask)
);
